/* rtl/hsm_pkg.sv */
// hsm_pkg: shared constants for the hashed set membership block
// no dependencies; used by the top level and its checker

package hsm_pkg;

	// request codes; the unused code behaves as a look up
	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	// result status codes
	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// field widths
	localparam int VALUE_W = 32;
	localparam int OP_W    = 2;
	localparam int BC_W    = 9;
	localparam int SLOT_W  = VALUE_W + 1;    // valid bit on top of the value

	// remainder unit: dividend bits retired per cycle
	localparam int DIV_STEP   = 4;
	localparam int DIV_CYCLES = VALUE_W / DIV_STEP;

endpackage

/* rtl/hashed_set_membership.sv */
// hashed_set_membership: each request goes from its input beat through the remainder unit,
// the base step, the slot reads and the commit to its result beat; no new request is taken
// until the commit, which waits while a result is stalled; the remainder unit and the single
// slot memory read port set the pace; reset (arst_n low) clears control and bucket_count to 256,
// then a clearing pass over every slot empties the store before the first input beat is taken
// depends on hsm_pkg and hsm_ram

module hashed_set_membership #(
	parameter int BUCKETS          = 256,
	parameter int SLOTS_PER_BUCKET = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration write channel (bucket count)
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [hsm_pkg::BC_W-1:0]     bucket_count,
	// request channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [hsm_pkg::OP_W-1:0]     op,
	input  logic [hsm_pkg::VALUE_W-1:0]  value,
	// result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         found,
	output logic                         status
);

	// storage geometry
	localparam int TotalSlots = BUCKETS * SLOTS_PER_BUCKET;
	localparam int AW         = (TotalSlots > 1) ? $clog2(TotalSlots) : 1;
	localparam int CW         = $clog2(SLOTS_PER_BUCKET + 1);
	localparam int DCW        = (hsm_pkg::DIV_CYCLES > 1) ? $clog2(hsm_pkg::DIV_CYCLES) : 1;
	localparam int BW         = hsm_pkg::BC_W;
	localparam int VW         = hsm_pkg::VALUE_W;
	// largest bucket count that can take effect
	localparam int BcMax      = (BUCKETS < 511) ? BUCKETS : 511;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_BASE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	state_t             state_q;
	logic [BW-1:0]      bucket_count_q;
	logic [BW-1:0]      active_bc;

	// request held for the whole sequence
	logic [1:0]         op_q;
	logic [VW-1:0]      key_q;
	logic [VW-1:0]      shf_q;      // dividend, consumed msb first
	logic [BW-1:0]      dvs_q;      // divisor latched at accept
	logic [BW-1:0]      rem_q;
	logic [BW-1:0]      rem_nxt;
	logic [DCW-1:0]     dcnt_q;

	// bucket walk
	logic [AW-1:0]      base_q;
	logic [CW-1:0]      cnt_q;
	logic               pend_s1;    // a slot read returns this cycle
	logic [AW-1:0]      addr_s1;
	logic               match_q;
	logic [AW-1:0]      match_at_q;
	logic               free_q;
	logic [AW-1:0]      free_at_q;

	// clearing pass
	logic [AW-1:0]      clr_addr_q;

	// result register
	logic               out_valid_q;
	logic               found_q;
	logic               status_q;
	logic               out_free;

	// memory ports
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [VW:0]        ram_wdata;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [VW:0]        ram_rdata;

	// commit decode
	logic               do_ins;
	logic               do_del;
	logic               full_hit;

	// config port never pushes back; the user must send writes only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	// zero acts as one, anything past the bucket array clamps to it
	always_comb begin
		if (bucket_count_q == '0) begin
			active_bc = BW'(1);
		end else if (bucket_count_q > BW'(BcMax)) begin
			active_bc = BW'(BcMax);
		end else begin
			active_bc = bucket_count_q;
		end
	end

	// remainder unit: DIV_STEP restoring steps per cycle, remainder stays below divisor
	always_comb begin
		logic [BW:0] t;
		rem_nxt = rem_q;
		t       = '0;
		for (int k = 0; k < hsm_pkg::DIV_STEP; k++) begin
			t = {rem_nxt, shf_q[VW-1-k]};
			if (t >= {1'b0, dvs_q}) begin
				rem_nxt = BW'(t - {1'b0, dvs_q});
			end else begin
				rem_nxt = t[BW-1:0];
			end
		end
	end

	// slot reads go out one per cycle while the walk counter is short of the bucket size
	assign ram_re    = (state_q == ST_SCAN) && (cnt_q != CW'(SLOTS_PER_BUCKET));
	assign ram_raddr = base_q + AW'(cnt_q);

	assign out_free  = !out_valid_q || !out_stall;

	// what the commit does to the store
	assign do_ins   = (op_q == hsm_pkg::OP_INSERT) && !match_q && free_q;
	assign do_del   = (op_q == hsm_pkg::OP_DELETE) && match_q;
	assign full_hit = (op_q == hsm_pkg::OP_INSERT) && !match_q && !free_q;

	// write port: clearing pass, or the commit of one request
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_addr_q;
		ram_wdata = '0;
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
		end else if (state_q == ST_COMMIT && out_free) begin
			if (do_ins) begin
				ram_we    = 1'b1;
				ram_waddr = free_at_q;
				ram_wdata = {1'b1, key_q};
			end else if (do_del) begin
				ram_we    = 1'b1;
				ram_waddr = match_at_q;
			end
		end
	end

	hsm_ram #(
		.WIDTH (hsm_pkg::SLOT_W),
		.DEPTH (TotalSlots)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// sequencer plus registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			bucket_count_q <= BW'(256);
			clr_addr_q     <= '0;
			op_q           <= hsm_pkg::OP_LOOKUP;
			key_q          <= '0;
			shf_q          <= '0;
			dvs_q          <= BW'(1);
			rem_q          <= '0;
			dcnt_q         <= '0;
			base_q         <= '0;
			cnt_q          <= '0;
			pend_s1        <= 1'b0;
			addr_s1        <= '0;
			match_q        <= 1'b0;
			match_at_q     <= '0;
			free_q         <= 1'b0;
			free_at_q      <= '0;
			out_valid_q    <= 1'b0;
			found_q        <= 1'b0;
			status_q       <= hsm_pkg::STATUS_DONE;
		end else begin
			if (cfg_valid && cfg_ready) begin
				bucket_count_q <= bucket_count;
			end

			// result beat leaves, unless the commit puts the next one in its place
			if (out_valid_q && !out_stall && state_q != ST_COMMIT) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(TotalSlots - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						op_q    <= op;
						key_q   <= value;
						shf_q   <= value;
						dvs_q   <= active_bc;
						rem_q   <= '0;
						dcnt_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q  <= rem_nxt;
					shf_q  <= shf_q << hsm_pkg::DIV_STEP;
					dcnt_q <= dcnt_q + DCW'(1);
					if (dcnt_q == DCW'(hsm_pkg::DIV_CYCLES - 1)) begin
						state_q <= ST_BASE;
					end
				end
				ST_BASE: begin
					// bucket index times bucket size, always inside the store
					base_q  <= AW'(32'(rem_q) * 32'(SLOTS_PER_BUCKET));
					cnt_q   <= '0;
					pend_s1 <= 1'b0;
					match_q <= 1'b0;
					free_q  <= 1'b0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					pend_s1 <= ram_re;
					addr_s1 <= ram_raddr;
					if (ram_re) begin
						cnt_q <= cnt_q + CW'(1);
					end
					// first matching slot and first empty slot, lowest address wins
					if (pend_s1) begin
						if (ram_rdata[VW]) begin
							if (!match_q && ram_rdata[VW-1:0] == key_q) begin
								match_q    <= 1'b1;
								match_at_q <= addr_s1;
							end
						end else if (!free_q) begin
							free_q    <= 1'b1;
							free_at_q <= addr_s1;
						end
					end
					if (!ram_re) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					// waits here while an earlier result is still held
					if (out_free) begin
						out_valid_q <= 1'b1;
						found_q     <= match_q;
						status_q    <= full_hit ? hsm_pkg::STATUS_FULL : hsm_pkg::STATUS_DONE;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// busy whenever not idle, including the clearing pass
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign status    = status_q;

endmodule

/* rtl/hsm_ram.sv */
// hsm_ram: generic single-port-write, single-port-read RAM, registered read
// no dependencies

module hsm_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 2048
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/hsm_checker.sv */
// hsm_checker: port-level assertions for hashed_set_membership, bound to the top level
// depends on hsm_pkg

module hsm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic found,
	input logic status
);

	// a held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found) && $stable(status))
		else $error("result beat changed while stalled");

	// a full refusal only happens for an absent value
	a_full_absent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == hsm_pkg::STATUS_FULL |-> !found)
		else $error("full status with found set");

	// after a request beat the block is busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while previous one in flight");

	// no result can appear in the cycle right after a request beat
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result appeared too early");

endmodule

bind hashed_set_membership hsm_checker u_hsm_checker (.*);
